### src/ddsd_pkg.sv
package ddsd_pkg;

  typedef enum logic [2:0] {
    CMD_SET_WHOLE = 3'd0,
    CMD_SET_LEFT  = 3'd1,
    CMD_SET_RIGHT = 3'd2,
    CMD_SET_DIGIT = 3'd3,
    CMD_SCAN      = 3'd4,
    CMD_BLANK     = 3'd5
  } cmd_e_t;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  localparam int RQ_DEPTH = 2;

  localparam logic [15:0] RECIP10   = 16'd52429;
  localparam int          SHIFT10   = 19;
  localparam logic [16:0] RECIP100  = 17'd83887;
  localparam int          SHIFT100  = 23;
  localparam logic [16:0] RECIP1000 = 17'd67109;
  localparam int          SHIFT1000 = 26;
  localparam logic [7:0]  RECIP10_NARROW = 8'd205;
  localparam int          SHIFT10_NARROW = 11;

  localparam logic [3:0] SEL_BASE   = 4'b0001;
  localparam logic [7:0] BLANK_BYTE = 8'h00;

  typedef struct packed {
    cmd_e_t      op;
    logic [15:0] number;
    logic [1:0]  position;
    logic [12:0] q10;
    logic [9:0]  q100;
    logic [6:0]  q1000;
  } cq_entry_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } cq_stat_t;

endpackage

### src/ddsd_front.sv
module ddsd_front (
  input  logic [2:0]           in_cmd,
  input  logic [15:0]          in_number,
  input  logic [1:0]           in_position,
  input  logic                 in_push,
  input  ddsd_pkg::cq_stat_t   q_stat,
  output logic                 q_wr_en,
  output ddsd_pkg::cq_entry_t  q_wr_entry
);
  import ddsd_pkg::*;

  logic [31:0] prod10;
  logic [32:0] prod100;
  logic [32:0] prod1000;
  logic        cmd_known;

  always_comb begin
    prod10   = {16'd0, in_number} * {16'd0, RECIP10};
    prod100  = {17'd0, in_number} * {16'd0, RECIP100};
    prod1000 = {17'd0, in_number} * {16'd0, RECIP1000};
  end

  always_comb begin
    unique case (in_cmd)
      CMD_SET_WHOLE, CMD_SET_LEFT, CMD_SET_RIGHT,
      CMD_SET_DIGIT, CMD_SCAN, CMD_BLANK: cmd_known = 1'b1;
      default:                            cmd_known = 1'b0;
    endcase
  end

  always_comb begin
    q_wr_en             = in_push && !q_stat.full && cmd_known;
    q_wr_entry.op       = cmd_e_t'(in_cmd);
    q_wr_entry.number   = in_number;
    q_wr_entry.position = in_position;
    q_wr_entry.q10      = prod10[SHIFT10 +: 13];
    q_wr_entry.q100     = prod100[SHIFT100 +: 10];
    q_wr_entry.q1000    = prod1000[SHIFT1000 +: 7];
  end

endmodule

### src/ddsd_cmd_q.sv
module ddsd_cmd_q (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  ddsd_pkg::cq_entry_t  wr_entry,
  input  logic                 rd_en,
  output ddsd_pkg::cq_entry_t  head,
  output ddsd_pkg::cq_stat_t   stat
);
  import ddsd_pkg::*;

  cq_entry_t               mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0]        count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CQ_CW'(wr_en) - CQ_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_comb begin
    head            = mem_r[rd_ptr_r];
    stat.head_valid = (count_r != '0);
    stat.full       = (count_r == CQ_CW'(CQ_DEPTH));
  end

endmodule

### src/ddsd_back.sv
module ddsd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddsd_pkg::cq_entry_t  head,
  input  ddsd_pkg::cq_stat_t   q_stat,
  output logic                 q_rd_en,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_expander_byte
);
  import ddsd_pkg::*;

  logic [3:0]  digit_r [4];
  logic [3:0]  digit_nxt [4];
  logic [1:0]  scan_r, scan_nxt;

  logic [7:0]  rq_data_r [RQ_DEPTH];
  logic        rq_wr_ptr_r, rq_wr_ptr_nxt;
  logic        rq_rd_ptr_r, rq_rd_ptr_nxt;
  logic [1:0]  rq_count_r, rq_count_nxt;

  logic [15:0] rem0;
  logic [12:0] rem1;
  logic [9:0]  rem2;
  logic [14:0] prod3;
  logic [3:0]  t3;
  logic [6:0]  rem3;
  logic [7:0]  pair_byte;
  logic [15:0] pair_prod;
  logic [4:0]  pair_t;
  logic [7:0]  pair_ones;
  logic [4:0]  pair_tens;

  logic        wants_result;
  logic [7:0]  result_byte;
  logic        rq_pop, rq_push, rq_room;

  always_comb begin
    rem0      = head.number - ({head.q10, 3'b000} + {2'b00, head.q10, 1'b0});
    rem1      = head.q10 - ({head.q100, 3'b000} + {2'b00, head.q100, 1'b0});
    rem2      = head.q100 - ({head.q1000, 3'b000} + {2'b00, head.q1000, 1'b0});
    prod3     = {8'd0, head.q1000} * {7'd0, RECIP10_NARROW};
    t3        = prod3[SHIFT10_NARROW +: 4];
    rem3      = head.q1000 - ({t3, 3'b000} + {2'b00, t3, 1'b0});
    pair_byte = head.number[7:0];
    pair_prod = {8'd0, pair_byte} * {8'd0, RECIP10_NARROW};
    pair_t    = pair_prod[SHIFT10_NARROW +: 5];
    pair_ones = pair_byte - ({pair_t, 3'b000} + {2'b00, pair_t, 1'b0});
    if (pair_t >= 5'd20) begin
      pair_tens = pair_t - 5'd20;
    end else if (pair_t >= 5'd10) begin
      pair_tens = pair_t - 5'd10;
    end else begin
      pair_tens = pair_t;
    end
  end

  always_comb begin
    unique case (head.op)
      CMD_SCAN, CMD_BLANK: wants_result = 1'b1;
      default:             wants_result = 1'b0;
    endcase
  end

  always_comb begin
    rq_pop  = out_pop && (rq_count_r != 2'd0);
    rq_room = (rq_count_r != 2'd2) || rq_pop;
    q_rd_en = q_stat.head_valid && (!wants_result || rq_room);
    rq_push = q_rd_en && wants_result;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      digit_nxt[i] = digit_r[i];
    end
    scan_nxt    = scan_r;
    result_byte = BLANK_BYTE;
    if (q_rd_en) begin
      unique case (head.op)
        CMD_SET_WHOLE: begin
          digit_nxt[0] = rem0[3:0];
          digit_nxt[1] = rem1[3:0];
          digit_nxt[2] = rem2[3:0];
          digit_nxt[3] = rem3[3:0];
        end
        CMD_SET_LEFT: begin
          digit_nxt[2] = pair_ones[3:0];
          digit_nxt[3] = pair_tens[3:0];
        end
        CMD_SET_RIGHT: begin
          digit_nxt[0] = pair_ones[3:0];
          digit_nxt[1] = pair_tens[3:0];
        end
        CMD_SET_DIGIT: begin
          digit_nxt[head.position] = rem0[3:0];
        end
        CMD_SCAN: begin
          result_byte = {SEL_BASE << scan_r, digit_r[scan_r]};
          scan_nxt    = scan_r + 2'd1;
        end
        CMD_BLANK: begin
          result_byte = BLANK_BYTE;
        end
        default: begin
          result_byte = BLANK_BYTE;
        end
      endcase
    end
  end

  always_comb begin
    rq_wr_ptr_nxt = rq_push ? ~rq_wr_ptr_r : rq_wr_ptr_r;
    rq_rd_ptr_nxt = rq_pop ? ~rq_rd_ptr_r : rq_rd_ptr_r;
    rq_count_nxt  = rq_count_r + 2'(rq_push) - 2'(rq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r[0]  <= 4'd1;
      digit_r[1]  <= 4'd2;
      digit_r[2]  <= 4'd3;
      digit_r[3]  <= 4'd4;
      scan_r      <= 2'd0;
      rq_wr_ptr_r <= 1'b0;
      rq_rd_ptr_r <= 1'b0;
      rq_count_r  <= 2'd0;
    end else begin
      digit_r     <= digit_nxt;
      scan_r      <= scan_nxt;
      rq_wr_ptr_r <= rq_wr_ptr_nxt;
      rq_rd_ptr_r <= rq_rd_ptr_nxt;
      rq_count_r  <= rq_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_data_r[rq_wr_ptr_r] <= result_byte;
    end
  end

  always_comb begin
    out_empty         = (rq_count_r == 2'd0);
    out_expander_byte = rq_data_r[rq_rd_ptr_r];
  end

endmodule

### src/decimal_digit_scan_display.sv
// Four-digit multiplexed decimal display driver. Commands enter through a
// push/full port and one command is taken per cycle while full is low:
// set-whole, set-left, set-right and set-digit load decimal digits into the
// four-digit store; scan tick returns the current digit in the low nibble
// with its one-hot select in the upper nibble and advances the scan; blank
// returns 0x00. Codes 6 and 7 are dropped. A scan or blank result passes
// through the four-entry command queue and then the two-entry result queue
// before it appears on the pop side. The front splits the number into
// decimal quotients with constant reciprocal multiplies before the command
// queue; the back finishes the digits and updates the store. Full rises only
// when the result side stalls long enough to fill the command queue.
module decimal_digit_scan_display (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_number,
  input  logic [1:0]  in_position,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_expander_byte
);
  import ddsd_pkg::*;

  cq_stat_t  q_stat;
  cq_entry_t q_wr_entry;
  cq_entry_t q_head;
  logic      q_wr_en;
  logic      q_rd_en;

  ddsd_front u_front (
    .in_cmd      (in_cmd),
    .in_number   (in_number),
    .in_position (in_position),
    .in_push     (push),
    .q_stat      (q_stat),
    .q_wr_en     (q_wr_en),
    .q_wr_entry  (q_wr_entry)
  );

  ddsd_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr_en),
    .wr_entry (q_wr_entry),
    .rd_en    (q_rd_en),
    .head     (q_head),
    .stat     (q_stat)
  );

  ddsd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_stat            (q_stat),
    .q_rd_en           (q_rd_en),
    .out_empty         (empty),
    .out_pop           (pop),
    .out_expander_byte (out_expander_byte)
  );

  assign full = q_stat.full;

endmodule
